@@ src/epe_pkg.sv @@
// Package: types, constants and helper functions of the event plane estimator.
package epe_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int PARTICLE_CAP  = 1024;
  localparam int STEPS         = 16;
  localparam int STEP_BITS     = 4;
  localparam int SUM_BITS      = 26;
  localparam int XY_BITS       = 38;
  localparam int Z_BITS        = 18;

  localparam logic signed [15:0] WIN_A_LOW_RST  = -16'sd2458;
  localparam logic signed [15:0] WIN_A_HIGH_RST = -16'sd1638;
  localparam logic signed [15:0] WIN_B_LOW_RST  = 16'sd1638;
  localparam logic signed [15:0] WIN_B_HIGH_RST = 16'sd2458;

  localparam logic [1:0] REG_WIN_A_LOW  = 2'd0;
  localparam logic [1:0] REG_WIN_A_HIGH = 2'd1;
  localparam logic [1:0] REG_WIN_B_LOW  = 2'd2;
  localparam logic [1:0] REG_WIN_B_HIGH = 2'd3;

  typedef struct packed {
    logic signed [15:0] azimuth;
    logic signed [15:0] pseudorapidity;
    logic               particle_present;
    logic               event_end;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] plane_a;
    logic signed [15:0] plane_b;
    logic signed [15:0] resolution_term;
  } out_item_t;

  typedef struct packed {
    logic                 latch_in;
    logic                 load_vec_a;
    logic                 load_vec_b;
    logic                 load_res;
    logic                 iterate;
    logic [STEP_BITS-1:0] step;
    logic                 accumulate;
    logic                 push;
  } epe_cmd_t;

  function automatic logic signed [Z_BITS-1:0] arctan(input logic [STEP_BITS-1:0] i);
    logic signed [Z_BITS-1:0] r;
    case (i)
      4'd0:    r = 18'sd8192;
      4'd1:    r = 18'sd4836;
      4'd2:    r = 18'sd2555;
      4'd3:    r = 18'sd1297;
      4'd4:    r = 18'sd651;
      4'd5:    r = 18'sd326;
      4'd6:    r = 18'sd163;
      4'd7:    r = 18'sd81;
      4'd8:    r = 18'sd41;
      4'd9:    r = 18'sd20;
      4'd10:   r = 18'sd10;
      4'd11:   r = 18'sd5;
      4'd12:   r = 18'sd3;
      4'd13:   r = 18'sd1;
      4'd14:   r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/epe_datapath.sv @@
// Datapath: config registers, window sums, shared CORDIC and result register.
module epe_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  epe_pkg::in_item_t  in_item,
  input  epe_pkg::epe_cmd_t  cmd,
  output epe_pkg::out_item_t out_item
);

  localparam int XB = epe_pkg::XY_BITS;
  localparam int ZB = epe_pkg::Z_BITS;
  localparam int SB = epe_pkg::SUM_BITS;

  logic signed [15:0] win_a_low, win_a_high, win_b_low, win_b_high;
  logic signed [15:0] eta;
  logic signed [SB-1:0] sin_a, cos_a, sin_b, cos_b;
  logic signed [XB-1:0] x, y;
  logic signed [ZB-1:0] z;
  logic rot_mode, flip, zero_flag;
  logic signed [15:0] plane_a_r, plane_b_r;

  // fold a binary angle into [-quarter, quarter] for rotation mode
  function automatic logic [ZB:0] fold(input logic signed [15:0] a);
    logic signed [ZB-1:0] za;
    logic f;
    za = ZB'(a);
    f  = 1'b0;
    if (za > 18'sd16384) begin
      za = za - 18'sd32768;
      f  = 1'b1;
    end else if (za < -18'sd16384) begin
      za = za + 18'sd32768;
      f  = 1'b1;
    end
    return {f, za};
  endfunction

  function automatic logic signed [15:0] trig_out(input logic signed [XB-1:0] v,
                                                  input logic f);
    logic signed [XB-1:0] t;
    logic signed [15:0] r;
    t = (v + XB'(2)) >>> 2;
    if (t > XB'(16384)) r = 16'sd16384;
    else if (t < -XB'(16384)) r = -16'sd16384;
    else r = t[15:0];
    return f ? -r : r;
  endfunction

  function automatic logic signed [15:0] half_angle(input logic signed [ZB-1:0] a,
                                                    input logic zf);
    logic signed [ZB-1:0] c;
    if (a > 18'sd32768) c = 18'sd32768;
    else if (a < -18'sd32768) c = -18'sd32768;
    else c = a;
    c = c >>> 1;
    return zf ? 16'sd0 : c[15:0];
  endfunction

  function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] s,
                                                   input logic signed [15:0] v);
    logic signed [SB:0] t;
    t = {s[SB-1], s} + (SB+1)'(v);
    if (t[SB] != t[SB-1]) return t[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    return t[SB-1:0];
  endfunction

  logic [ZB:0] fold_in, fold_res;
  logic signed [15:0] plane_now, res_angle;
  logic signed [16:0] diff;
  logic signed [XB-1:0] xs, ys, vx, vy;
  logic signed [SB-1:0] vs, vc;
  logic dir, in_a, in_b, vzero;
  logic signed [15:0] s_val, c_val;

  assign fold_in   = fold({in_item.azimuth[14:0], 1'b0});
  assign plane_now = half_angle(z, zero_flag);
  assign diff      = {plane_a_r[15], plane_a_r} - {plane_now[15], plane_now};
  assign res_angle = {diff[14:0], 1'b0};
  assign fold_res  = fold(res_angle);
  assign xs        = x >>> cmd.step;
  assign ys        = y >>> cmd.step;
  assign dir       = rot_mode ? (z >= 0) : !(y > 0);
  assign vs        = cmd.load_vec_a ? sin_a : sin_b;
  assign vc        = cmd.load_vec_a ? cos_a : cos_b;
  assign vx        = {{(XB-SB-8){vc[SB-1]}}, vc, 8'd0};
  assign vy        = {{(XB-SB-8){vs[SB-1]}}, vs, 8'd0};
  assign vzero     = (vs == '0) && (vc == '0);
  assign s_val     = trig_out(y, flip);
  assign c_val     = trig_out(x, flip);
  assign in_a      = (eta > win_a_low) && (eta < win_a_high);
  assign in_b      = (eta > win_b_low) && (eta < win_b_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_a_low  <= epe_pkg::WIN_A_LOW_RST;
      win_a_high <= epe_pkg::WIN_A_HIGH_RST;
      win_b_low  <= epe_pkg::WIN_B_LOW_RST;
      win_b_high <= epe_pkg::WIN_B_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        epe_pkg::REG_WIN_A_LOW:  win_a_low  <= cfg_data;
        epe_pkg::REG_WIN_A_HIGH: win_a_high <= cfg_data;
        epe_pkg::REG_WIN_B_LOW:  win_b_low  <= cfg_data;
        epe_pkg::REG_WIN_B_HIGH: win_b_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.push) begin
      sin_a <= '0;
      cos_a <= '0;
      sin_b <= '0;
      cos_b <= '0;
    end else if (cmd.accumulate) begin
      if (in_a) begin
        sin_a <= sat_add(sin_a, s_val);
        cos_a <= sat_add(cos_a, c_val);
      end
      if (in_b) begin
        sin_b <= sat_add(sin_b, s_val);
        cos_b <= sat_add(cos_b, c_val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      eta      <= in_item.pseudorapidity;
      x        <= XB'(39797);
      y        <= '0;
      z        <= fold_in[ZB-1:0];
      flip     <= fold_in[ZB];
      rot_mode <= 1'b1;
    end else if (cmd.load_res) begin
      x        <= XB'(39797);
      y        <= '0;
      z        <= fold_res[ZB-1:0];
      flip     <= fold_res[ZB];
      rot_mode <= 1'b1;
    end else if (cmd.load_vec_a || cmd.load_vec_b) begin
      rot_mode  <= 1'b0;
      zero_flag <= vzero;
      if (vx < 0) begin
        if (vy >= 0) begin
          x <= vy;
          y <= -vx;
          z <= 18'sd16384;
        end else begin
          x <= -vy;
          y <= vx;
          z <= -18'sd16384;
        end
      end else begin
        x <= vx;
        y <= vy;
        z <= '0;
      end
    end else if (cmd.iterate) begin
      if (dir) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - epe_pkg::arctan(cmd.step);
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + epe_pkg::arctan(cmd.step);
      end
    end
    if (cmd.load_vec_b) plane_a_r <= plane_now;
    // held apart until push, the output register may still hold the previous item
    if (cmd.load_res) plane_b_r <= plane_now;
    if (cmd.push) begin
      out_item.plane_a         <= plane_a_r;
      out_item.plane_b         <= plane_b_r;
      out_item.resolution_term <= c_val;
    end
  end

endmodule

@@ src/epe_ctrl.sv @@
// Controller: item handshake, particle count and CORDIC sequencing.
module epe_ctrl #(
  parameter int PARTICLE_CAP = epe_pkg::PARTICLE_CAP
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              present,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output epe_pkg::epe_cmd_t cmd
);

  localparam int CW = $clog2(PARTICLE_CAP + 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_ROT  = 10'b0000000010,
    S_ACC  = 10'b0000000100,
    S_LDA  = 10'b0000001000,
    S_VA   = 10'b0000010000,
    S_LDB  = 10'b0000100000,
    S_VB   = 10'b0001000000,
    S_LDR  = 10'b0010000000,
    S_RES  = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [epe_pkg::STEP_BITS-1:0] step;
  logic [CW-1:0] count;
  logic end_flag, accept, take;
  logic last_step;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign take      = accept && present && (count < CW'(PARTICLE_CAP));
  assign last_step = (step == '1);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.step       = step;
    cmd.latch_in   = take;
    case (state)
      S_IDLE: begin
        if (take) state_next = S_ROT;
        else if (accept && last) state_next = S_LDA;
      end
      S_ROT: begin
        cmd.iterate = 1'b1;
        if (last_step) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.accumulate = 1'b1;
        state_next = end_flag ? S_LDA : S_IDLE;
      end
      S_LDA: begin
        cmd.load_vec_a = 1'b1;
        state_next = S_VA;
      end
      S_VA: begin
        cmd.iterate = 1'b1;
        if (last_step) state_next = S_LDB;
      end
      S_LDB: begin
        cmd.load_vec_b = 1'b1;
        state_next = S_VB;
      end
      S_VB: begin
        cmd.iterate = 1'b1;
        if (last_step) state_next = S_LDR;
      end
      S_LDR: begin
        cmd.load_res = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        cmd.iterate = 1'b1;
        if (last_step) state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.push = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      count     <= '0;
      end_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= cmd.iterate ? step + 1'b1 : '0;
      if (accept) end_flag <= last;
      if (cmd.push) count <= '0;
      else if (take) count <= count + 1'b1;
      if (cmd.push) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_take_rotates: assert property (@(posedge clk) disable iff (rst)
    take |=> state == S_ROT) else $error("particle not sent to rotation");
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> step == '0) else $error("step counter not cleared");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || out_ready)) else $error("result overwritten");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(PARTICLE_CAP)) else $error("particle count overrun");
`endif

endmodule

@@ src/event_plane_estimator.sv @@
// Top level: second-harmonic event plane estimator for two eta windows.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_item (epe_pkg::in_item_t)
//  out     | output    | out_valid / out_ready | out_item (epe_pkg::out_item_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An item counted as a particle is accepted, then takes 16 CORDIC rotation steps on
// the shared unit and one accumulate; an event end adds two 16-step vectoring
// passes and one 16-step rotation plus loads.
// Reset (rst, synchronous) clears the sums and restores the window bounds.
// A result waits in the output register; a stalled result holds the block
// in its last state until the register frees.
module event_plane_estimator #(
  parameter int PARTICLE_CAP = epe_pkg::PARTICLE_CAP
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  epe_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output epe_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  epe_pkg::epe_cmd_t cmd;

  assign cfg_ready = 1'b1;

  epe_ctrl #(.PARTICLE_CAP(PARTICLE_CAP)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .present   (in_item.particle_present),
    .last      (in_item.event_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  epe_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_item  (out_item)
  );

endmodule
